/* hdl/bounded_field_packer_top_macros.svh */
// Assertion macros for the bounded field packer.
// Depends on nothing; included by bounded_field_packer_top.sv.
`ifndef BOUNDED_FIELD_PACKER_TOP_MACROS_SVH
`define BOUNDED_FIELD_PACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BFP_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("bfp assertion failed");
// next-cycle implication
`define BFP_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("bfp assertion failed");
`else
`define BFP_ASSERT_IMPL(label, clk, rst, a, b)
`define BFP_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

/* hdl/bfp_pkg.sv */
// Shared types and constants of the bounded field packer.
// Depends on nothing; used by every module of the block.
package bfp_pkg;

   localparam int SIZE_BITS = 16;
   // width for size arithmetic: covers SIZE_BITS, the 16-bit capacity and a carry
   localparam int WIDE_W = ((SIZE_BITS > 16) ? SIZE_BITS : 16) + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_BOUND = 3'd1;
   localparam logic [2:0] MODE_BOOL  = 3'd2;
   localparam logic [2:0] MODE_WORD  = 3'd3;
   localparam logic [2:0] MODE_DWORD = 3'd4;
   localparam logic [2:0] MODE_RAW   = 3'd5;

   typedef struct packed {
      logic [2:0]  mode;
      logic        is_signed;
      logic [63:0] value;
      logic [63:0] min_value;
      logic [63:0] max_value;
      logic        run_end;
   } req_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  out_byte;
      logic [15:0] byte_offset;
      logic        last;
      logic        field_ok;
      logic        run_end_echo;
      logic [15:0] size_after;
   } rsp_type;

   // one queued job: bytes left-aligned in data, sent from the top down
   typedef struct packed {
      logic        byte_valid;
      logic [63:0] data;
      logic [2:0]  last_idx;
      logic [15:0] base;
      logic        field_ok;
      logic        run_end_echo;
      logic [15:0] size_after;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [15:0] size_to_16(input logic [SIZE_BITS-1:0] v);
      logic [WIDE_W-1:0] ext;
      ext = {{(WIDE_W-SIZE_BITS){1'b0}}, v};
      return ext[15:0];
   endfunction

endpackage

/* hdl/bounded_field_packer_top.sv */
// Top level of the bounded field packer: front end, job queue, back end.
// Depends on bfp_pkg, bfp_front, bfp_queue, bfp_back and the macros header.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  bfp_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  bfp_pkg::rsp_type
//   csr      in         csr_valid/csr_ready  buffer capacity, 16 bits
//
// Rate: one result per cycle out of the back end while rsp_stall is low; each
//   item gives one result per byte it writes (1, 2, 4 or 8), one if none; the byte
//   serializer sets that. The front end takes one item a cycle while req_stall is low.
// Path: an item is registered in the front stage (classify), checked and written
//   into the queue (check), then registered in the output register (output).
// Reset: synchronous, clears state at once; no clearing pass.
// Stalls: rsp_stall holds the output register; the four-entry queue then
//   fills, and req_stall rises once both the queue and the front stage are full.
`include "bounded_field_packer_top_macros.svh"

module bounded_field_packer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   logic                  q_push, q_pop;
   bfp_pkg::cmd_type      q_push_cmd, q_head;
   bfp_pkg::q_status_type q_status;

   // capacity register always takes a write
   assign csr_ready = 1'b1;

   // classify + range/capacity check, owns used size and valid flag
   bfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cap_we    (csr_valid),
      .cap_data  (csr_data),
      .q_status  (q_status),
      .push      (q_push),
      .push_cmd  (q_push_cmd)
   );

   // decouples the checking pace from the byte pace
   bfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   // one byte per transfer, most significant first
   bfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // front never pushes into a full queue
   `BFP_ASSERT_IMPL(a_no_push_full, clock, reset, q_push, !q_status.full)
   // queue is empty once reset is applied
   `BFP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, q_status.empty)
   // pending work keeps the output busy after a transfer
   `BFP_ASSERT_NEXT(a_out_busy, clock, reset, rsp_valid && !rsp_stall && !q_status.empty,
                    rsp_valid)

endmodule

/* hdl/bfp_front.sv */
// Front end: accepts items, classifies them, checks range and capacity, keeps state.
// Depends on bfp_pkg.
module bfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bfp_pkg::req_type      req_data,
   input  logic                  cap_we,
   input  logic [15:0]           cap_data,
   input  bfp_pkg::q_status_type q_status,
   output logic                  push,
   output bfp_pkg::cmd_type      push_cmd
);

   typedef enum logic [1:0] {
      KIND_START,
      KIND_FIELD,
      KIND_IGNORE
   } kind_type;

   function automatic logic le64(input logic [63:0] a, input logic [63:0] b,
                                 input logic sgn);
      return {a[63] ^ sgn, a[62:0]} <= {b[63] ^ sgn, b[62:0]};
   endfunction

   // classified item
   logic        stage_valid_ff, stage_valid_in;
   kind_type    kind_ff, kind_in;
   logic [3:0]  nbytes_ff, nbytes_in;
   logic [63:0] data_ff, data_in;
   logic        range_bad_ff, range_bad_in;
   logic        echo_ff;

   logic [bfp_pkg::SIZE_BITS-1:0] used_ff, used_in;
   logic                          ok_ff, ok_in;
   logic [15:0]                   cap_ff;

   logic        accept;
   logic [63:0] range, diff;
   logic [bfp_pkg::WIDE_W-1:0] sum_w, cap_w, mask_w;
   logic        fail;

   assign req_stall = stage_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = stage_valid_ff && !q_status.full;

   assign range = req_data.max_value - req_data.min_value;
   assign diff  = req_data.value - req_data.min_value;

   always_comb begin
      kind_in      = KIND_FIELD;
      nbytes_in    = 4'd1;
      data_in      = '0;
      range_bad_in = 1'b0;
      case (req_data.mode)
         bfp_pkg::MODE_START: kind_in = KIND_START;
         bfp_pkg::MODE_BOUND: begin
            range_bad_in = !le64(req_data.min_value, req_data.value, req_data.is_signed) ||
                           !le64(req_data.value, req_data.max_value, req_data.is_signed);
            if (range[63:8] == '0) begin
               nbytes_in = 4'd1;
               data_in   = {diff[7:0], 56'd0};
            end else if (range[63:16] == '0) begin
               nbytes_in = 4'd2;
               data_in   = {diff[15:0], 48'd0};
            end else if (range[63:32] == '0) begin
               nbytes_in = 4'd4;
               data_in   = {diff[31:0], 32'd0};
            end else begin
               nbytes_in = 4'd8;
               data_in   = diff;
            end
         end
         bfp_pkg::MODE_BOOL:  data_in = {7'd0, (req_data.value != '0), 56'd0};
         bfp_pkg::MODE_WORD: begin
            nbytes_in = 4'd4;
            data_in   = {req_data.value[31:0], 32'd0};
         end
         bfp_pkg::MODE_DWORD: begin
            nbytes_in = 4'd8;
            data_in   = req_data.value;
         end
         bfp_pkg::MODE_RAW:   data_in = {req_data.value[7:0], 56'd0};
         default:             kind_in = KIND_IGNORE;
      endcase
   end

   // capacity check against current state
   assign mask_w = {{(bfp_pkg::WIDE_W-bfp_pkg::SIZE_BITS){1'b0}}, {bfp_pkg::SIZE_BITS{1'b1}}};
   assign sum_w  = {{(bfp_pkg::WIDE_W-bfp_pkg::SIZE_BITS){1'b0}}, used_ff} +
                   {{(bfp_pkg::WIDE_W-4){1'b0}}, nbytes_ff};
   always_comb begin
      cap_w = {{(bfp_pkg::WIDE_W-16){1'b0}}, cap_ff};
      if (cap_w > mask_w) cap_w = mask_w;
   end
   assign fail = !ok_ff || range_bad_ff || (sum_w > cap_w);

   always_comb begin
      used_in               = used_ff;
      ok_in                 = ok_ff;
      push_cmd.byte_valid   = 1'b0;
      push_cmd.data         = '0;
      push_cmd.last_idx     = '0;
      push_cmd.base         = '0;
      push_cmd.field_ok     = ok_ff;
      push_cmd.run_end_echo = echo_ff;
      push_cmd.size_after   = bfp_pkg::size_to_16(used_ff);
      unique case (kind_ff)
         KIND_START: begin
            used_in             = '0;
            ok_in               = 1'b1;
            push_cmd.field_ok   = 1'b1;
            push_cmd.size_after = '0;
         end
         KIND_FIELD: begin
            if (fail) begin
               ok_in             = 1'b0;
               push_cmd.field_ok = 1'b0;
            end else begin
               used_in             = sum_w[bfp_pkg::SIZE_BITS-1:0];
               push_cmd.byte_valid = 1'b1;
               push_cmd.data       = data_ff;
               push_cmd.last_idx   = nbytes_ff[2:0] - 3'd1;
               push_cmd.base       = bfp_pkg::size_to_16(used_ff);
               push_cmd.field_ok   = 1'b1;
               push_cmd.size_after = sum_w[15:0];
            end
         end
         KIND_IGNORE: ;
         default: ;
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept)    stage_valid_in = 1'b1;
      else if (push) stage_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         used_ff        <= '0;
         ok_ff          <= 1'b1;
         cap_ff         <= 16'hFFFF;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (push) begin
            used_ff <= used_in;
            ok_ff   <= ok_in;
         end
         if (cap_we) cap_ff <= cap_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= kind_in;
         nbytes_ff    <= nbytes_in;
         data_ff      <= data_in;
         range_bad_ff <= range_bad_in;
         echo_ff      <= req_data.run_end;
      end
   end

endmodule

/* hdl/bfp_queue.sv */
// Short job queue between the front and back ends.
// Depends on bfp_pkg.
module bfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bfp_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output bfp_pkg::cmd_type      head,
   output bfp_pkg::q_status_type status
);

   bfp_pkg::cmd_type entry_ff [bfp_pkg::QUEUE_DEPTH];
   logic [bfp_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bfp_pkg::QUEUE_AW:0]   count_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (bfp_pkg::QUEUE_AW+1)'(bfp_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* hdl/bfp_back.sv */
// Back end: one registered result per byte of each job, or one if it has none.
// Depends on bfp_pkg.
module bfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bfp_pkg::cmd_type      head,
   input  bfp_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bfp_pkg::rsp_type      rsp_data
);

   logic             rsp_valid_ff;
   bfp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [2:0]       idx_ff;
   logic             out_free, take, last_byte;
   logic [63:0]      shifted;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take      = out_free && !q_status.empty;
   assign last_byte = (idx_ff == head.last_idx);
   assign pop       = take && last_byte;
   assign shifted   = head.data << {idx_ff, 3'b000};

   always_comb begin
      rsp_data_in.byte_valid   = head.byte_valid;
      rsp_data_in.out_byte     = shifted[63:56];
      rsp_data_in.byte_offset  = head.base + {13'd0, idx_ff};
      rsp_data_in.last         = last_byte;
      rsp_data_in.field_ok     = head.field_ok;
      rsp_data_in.run_end_echo = head.run_end_echo;
      rsp_data_in.size_after   = head.size_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (out_free) rsp_valid_ff <= !q_status.empty;
         if (take)     idx_ff <= last_byte ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
